FILE: design/gf2cm_pkg.sv
package gf2cm_pkg;

  localparam int unsigned NumCols    = 6;
  localparam int unsigned ColW       = 6;
  localparam int unsigned CfgW       = 3;
  localparam int unsigned MaxSizeDef = 6;
  localparam logic [CfgW-1:0] SizeRst = 3'd6;

  localparam int unsigned InTdataW  = ((NumCols * ColW + 7) / 8) * 8;
  localparam int unsigned OutTdataW = 8;

endpackage

FILE: design/gf2cm_matvec.sv
module gf2cm_matvec #(
  parameter int unsigned MAX_SIZE = gf2cm_pkg::MaxSizeDef,
  parameter int unsigned CW       = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1
) (
  input  logic [MAX_SIZE-1:0] amat_i [MAX_SIZE],
  input  logic [MAX_SIZE-1:0] vec_i,
  input  logic                ident_i,
  input  logic [CW-1:0]       idx_i,
  output logic [MAX_SIZE-1:0] col_o
);

  logic [MAX_SIZE-1:0] acc;

  always_comb begin
    acc = '0;
    for (int i = 0; i < MAX_SIZE; i++) begin
      if (vec_i[i]) begin
        acc = acc ^ amat_i[i];
      end
    end
  end

  // identity column while loading the first power
  assign col_o = ident_i ? (MAX_SIZE'(1) << idx_i) : acc;

endmodule

FILE: design/gf2cm_pivot.sv
module gf2cm_pivot #(
  parameter int unsigned N2 = gf2cm_pkg::MaxSizeDef * gf2cm_pkg::MaxSizeDef,
  parameter int unsigned TW = (N2 > 1) ? $clog2(N2) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          clr_i,
  input  logic          find_i,
  input  logic          ins_i,
  input  logic [N2-1:0] vec_i,
  output logic          t_hit_o,
  output logic [N2-1:0] rdata_o
);

  logic [N2-1:0] mem [N2];
  logic [N2-1:0] valid_q, valid_d;
  logic [N2-1:0] rdata_q;
  logic [TW-1:0] t_q;
  logic [TW-1:0] t_sel;

  // leading-one position
  always_comb begin
    t_sel = '0;
    for (int p = 0; p < N2; p++) begin
      if (vec_i[p]) begin
        t_sel = TW'(p);
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (clr_i) begin
      valid_d = '0;
    end else if (ins_i) begin
      valid_d[t_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (find_i) begin
      t_q     <= t_sel;
      rdata_q <= mem[t_sel];
    end
    if (ins_i) begin
      mem[t_q] <= vec_i;
    end
  end

  assign t_hit_o = valid_q[t_q];
  assign rdata_o = rdata_q;

endmodule

FILE: design/gf2_cyclic_matrix_test_unit.sv
// Channel   Dir  Handshake                     Payload (low bit up)
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: col0..col5, 6 bits each
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: is_cyclic
// cfg       in   cfg_we_i                      cfg_wdata_i: matrix_size
//
// One matrix per transfer; s_axis_tready is high only while idle.
// Per tested power: n column products, then pivot steps (RAM read, then eliminate or
// insert), at most k + 1 steps for power k; a power reducing to zero ends at the zero
// check. The finish step registers the result onto m_axis and then returns to idle.
// rst_ni clears control, sets matrix_size to 6; m_axis_tready low stalls the finish step.
module gf2_cyclic_matrix_test_unit #(
  parameter int unsigned MAX_SIZE = gf2cm_pkg::MaxSizeDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [gf2cm_pkg::InTdataW-1:0]    s_axis_tdata,  // col0..col5
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [gf2cm_pkg::OutTdataW-1:0]   m_axis_tdata,  // is_cyclic
  input  logic                              cfg_we_i,
  input  logic [gf2cm_pkg::CfgW-1:0]        cfg_wdata_i    // matrix_size
);

  localparam int unsigned N2 = MAX_SIZE * MAX_SIZE;
  localparam int unsigned TW = (N2 > 1) ? $clog2(N2) : 1;
  localparam int unsigned SW = $clog2(MAX_SIZE + 1);
  localparam int unsigned CW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StGen  = 3'd1;
  localparam logic [2:0] StFind = 3'd2;
  localparam logic [2:0] StElim = 3'd3;
  localparam logic [2:0] StFin  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [gf2cm_pkg::CfgW-1:0] size_q;
  logic [SW-1:0] n_cur, n_q, n_d;
  logic [SW-1:0] col_q, col_d, k_q, k_d;
  logic [TW-1:0] off_q, off_d;
  logic ident_q, ident_d;
  logic res_q, res_d;
  logic out_valid_q, out_valid_d, out_bit_q, out_bit_d;
  logic [N2-1:0] vec_q, vec_d;
  logic [MAX_SIZE-1:0] amat_q [MAX_SIZE];
  logic [MAX_SIZE-1:0] amat_in [MAX_SIZE];
  logic [MAX_SIZE-1:0] power_q [MAX_SIZE];
  logic [MAX_SIZE-1:0] row_mask;
  logic [MAX_SIZE-1:0] gen_col;
  logic [N2-1:0] piv_rdata;
  logic piv_hit, piv_clr, piv_find, piv_ins;
  logic in_xfer, gen_we;

  assign n_cur = (int'(size_q) > int'(MAX_SIZE)) ? SW'(MAX_SIZE) : SW'(size_q);

  always_comb begin
    for (int j = 0; j < MAX_SIZE; j++) begin
      row_mask[j] = (j < int'(n_cur));
    end
  end

  for (genvar i = 0; i < MAX_SIZE; i++) begin : g_cols
    if (i < gf2cm_pkg::NumCols) begin : g_in
      logic [gf2cm_pkg::ColW-1:0] raw;
      assign raw = s_axis_tdata[i*gf2cm_pkg::ColW +: gf2cm_pkg::ColW];
      assign amat_in[i] = (i < int'(n_cur)) ? (MAX_SIZE'(raw) & row_mask) : '0;
    end else begin : g_zero
      assign amat_in[i] = '0;
    end
  end

  gf2cm_matvec #(
    .MAX_SIZE(MAX_SIZE),
    .CW      (CW)
  ) u_matvec (
    .amat_i (amat_q),
    .vec_i  (power_q[col_q[CW-1:0]]),
    .ident_i(ident_q),
    .idx_i  (col_q[CW-1:0]),
    .col_o  (gen_col)
  );

  gf2cm_pivot #(
    .N2(N2),
    .TW(TW)
  ) u_pivot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_i  (piv_clr),
    .find_i (piv_find),
    .ins_i  (piv_ins),
    .vec_i  (vec_q),
    .t_hit_o(piv_hit),
    .rdata_o(piv_rdata)
  );

  assign s_axis_tready = (state_q == StIdle);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    col_d       = col_q;
    k_d         = k_q;
    off_d       = off_q;
    ident_d     = ident_q;
    res_d       = res_q;
    vec_d       = vec_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_bit_d   = out_bit_q;
    piv_clr     = 1'b0;
    piv_find    = 1'b0;
    piv_ins     = 1'b0;
    gen_we      = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          n_d     = n_cur;
          col_d   = '0;
          k_d     = '0;
          off_d   = '0;
          ident_d = 1'b1;
          piv_clr = 1'b1;
          if (n_cur == '0) begin
            res_d   = 1'b1;
            state_d = StFin;
          end else begin
            state_d = StGen;
          end
        end
      end
      StGen: begin
        gen_we = 1'b1;
        vec_d  = ((col_q == '0) ? '0 : vec_q) | (N2'(gen_col) << off_q);
        off_d  = off_q + TW'(n_q);
        col_d  = col_q + 1'b1;
        if (col_q == n_q - 1'b1) begin
          state_d = StFind;
        end
      end
      StFind: begin
        if (vec_q == '0) begin
          res_d   = 1'b0;
          state_d = StFin;
        end else begin
          piv_find = 1'b1;
          state_d  = StElim;
        end
      end
      StElim: begin
        if (piv_hit) begin
          vec_d   = vec_q ^ piv_rdata;
          state_d = StFind;
        end else begin
          piv_ins = 1'b1;
          if (k_q == n_q - 1'b1) begin
            res_d   = 1'b1;
            state_d = StFin;
          end else begin
            k_d     = k_q + 1'b1;
            col_d   = '0;
            off_d   = '0;
            ident_d = 1'b0;
            state_d = StGen;
          end
        end
      end
      StFin: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_bit_d   = res_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      size_q      <= gf2cm_pkg::SizeRst;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      col_q       <= '0;
      k_q         <= '0;
      off_q       <= '0;
      ident_q     <= 1'b1;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      n_q         <= n_d;
      col_q       <= col_d;
      k_q         <= k_d;
      off_q       <= off_d;
      ident_q     <= ident_d;
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q     <= res_d;
    vec_q     <= vec_d;
    out_bit_q <= out_bit_d;
    if (in_xfer) begin
      amat_q <= amat_in;
    end
    if (gen_we) begin
      power_q[col_q[CW-1:0]] <= gen_col;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(gf2cm_pkg::OutTdataW - 1){1'b0}}, out_bit_q};

endmodule
